// File: hdl/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg - shared constants for the character-LCD number writer
// Operation codes, display command bits and ASCII codes used when turning
// a request into cursor and data bytes.
// ----------------------------------------------------------------------------
package clcd_pkg;

  // Request operation codes
  localparam logic [2:0] OP_CHAR = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_SDEC = 3'd2;
  localparam logic [2:0] OP_HEX  = 3'd3;
  localparam logic [2:0] OP_BIN  = 3'd4;

  // Display controller command fields
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [6:0] ROW2_OFFSET   = 7'h40;
  localparam logic [1:0] TOP_ROW       = 2'd1;

  // ASCII codes
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_UPA   = 8'h41;
  localparam logic [7:0] ASCII_PLUS  = 8'h2B;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

endpackage

// File: hdl/char_lcd_number_writer.sv
// ----------------------------------------------------------------------------
// char_lcd_number_writer - cursor command and number bytes for a char LCD
// Turns one display request into a cursor command followed by data bytes.
// ----------------------------------------------------------------------------
//
// Usage:
//  - Input channel: drive the in_* fields and raise start; the request is
//    taken at a rising edge where start is high and busy is low.
//  - Result channel: each byte appears on out_bus_byte / out_is_data /
//    out_last for exactly one cycle, flagged by out_strobe. The receiver
//    cannot hold bytes off; it must take each one as it comes.
//  - Each request yields the cursor command (0x80 | address), then the
//    character or an optional sign and 'length' digits, MSB first, with
//    out_last set on the final byte.
//  - Pipeline: request register -> converter -> byte emitter -> output
//    register. A hex, binary or character request passes through each
//    of these registers in turn to reach the result ports; a decimal
//    request also runs shift-and-add-3 conversion, four bits per step.
//  - Throughput: the emitter sends one byte per cycle; a request yields
//    1 + sign + digits bytes (up to 18). The converter works on the next
//    request meanwhile, and the emitter loads it once it is converted,
//    in the cycle that sends the last byte, or at once when idle.
//  - Reset (rst_n low, synchronous) drops every request in flight and
//    clears out_strobe; busy is low after reset.
// ----------------------------------------------------------------------------
module char_lcd_number_writer #(
  parameter int MAX_DIGITS = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_operation,
  input  logic [1:0]            in_line,
  input  logic [5:0]            in_column,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [4:0]            in_length,
  input  logic [7:0]            in_character,
  output logic                  out_strobe,
  output logic [7:0]            out_bus_byte,
  output logic                  out_is_data,
  output logic                  out_last
);

  // Decimal digits needed to hold any VALUE_BITS-bit magnitude
  localparam int DEC_DIGITS = (VALUE_BITS * 3) / 10 + 1;
  localparam int BCD_W      = DEC_DIGITS * 4;
  localparam int DV_W       = MAX_DIGITS * 4;
  localparam int LEN_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  // Conversion takes four magnitude bits per cycle
  localparam int DD_BITS    = 4;
  localparam int DD_STEPS   = (VALUE_BITS + DD_BITS - 1) / DD_BITS;
  localparam int SH_W       = DD_STEPS * DD_BITS;
  localparam int CNT_W      = $clog2(DD_STEPS + 1);

  // Emitter phases
  localparam logic [1:0] PH_CMD  = 2'd0;
  localparam logic [1:0] PH_CHAR = 2'd1;
  localparam logic [1:0] PH_SIGN = 2'd2;
  localparam logic [1:0] PH_DIG  = 2'd3;

  // --------------------------------------------------------------------------
  // Stage 1: request register. Decode address, clamp length, take magnitude.
  // --------------------------------------------------------------------------
  logic                  s1_valid_r, s1_valid_nxt;
  logic [2:0]            s1_op_r;
  logic [7:0]            s1_cmd_r;
  logic [7:0]            s1_ch_r;
  logic [LEN_W-1:0]      s1_len_r;
  logic [VALUE_BITS-1:0] s1_mag_r;
  logic                  s1_neg_r;

  logic                  accept;
  logic                  s1_adv;
  logic                  s2_free;

  logic [6:0]            req_addr;
  logic [LEN_W-1:0]      req_len;
  logic                  req_neg;
  logic [VALUE_BITS-1:0] req_mag;

  assign busy   = s1_valid_r & ~s1_adv;
  assign accept = start & ~busy;
  assign s1_adv = s1_valid_r & s2_free;

  always_comb begin
    req_addr = {1'b0, in_column - 6'd1};
    if (in_line != clcd_pkg::TOP_ROW) begin
      req_addr = req_addr | clcd_pkg::ROW2_OFFSET;
    end
    if (int'(in_length) > MAX_DIGITS) begin
      req_len = LEN_W'(MAX_DIGITS);
    end else begin
      req_len = LEN_W'(in_length);
    end
    // most negative value negates to itself, which reads right as unsigned
    req_neg = (in_operation == clcd_pkg::OP_SDEC) & in_value[VALUE_BITS-1];
    req_mag = req_neg ? (~in_value + 1'b1) : in_value;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r  <= in_operation;
      s1_cmd_r <= clcd_pkg::CMD_SET_DDRAM | {1'b0, req_addr};
      s1_ch_r  <= in_character;
      s1_len_r <= req_len;
      s1_mag_r <= req_mag;
      s1_neg_r <= req_neg;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: converter. Decimal requests run shift-and-add-3 over the
  // magnitude, four bits per cycle; other requests skip the conversion.
  // --------------------------------------------------------------------------
  logic                  s2_valid_r, s2_valid_nxt;
  logic [CNT_W-1:0]      s2_cnt_r, s2_cnt_nxt;
  logic [SH_W-1:0]       s2_shift_r, s2_shift_nxt;
  logic [BCD_W-1:0]      s2_bcd_r, s2_bcd_nxt;
  logic [2:0]            s2_op_r;
  logic [7:0]            s2_cmd_r;
  logic [7:0]            s2_ch_r;
  logic [LEN_W-1:0]      s2_len_r;
  logic [VALUE_BITS-1:0] s2_mag_r;
  logic                  s2_neg_r;

  logic                  s2_done;
  logic                  s3_load;
  logic [BCD_W-1:0]      bcd_step;
  logic                  s1_is_dec;

  assign s2_done   = s2_valid_r & (s2_cnt_r == '0);
  assign s2_free   = ~s2_valid_r | s3_load;
  assign s1_is_dec = (s1_op_r == clcd_pkg::OP_UDEC) | (s1_op_r == clcd_pkg::OP_SDEC);

  // Four adjust-and-shift rounds, top magnitude bits first
  always_comb begin
    bcd_step = s2_bcd_r;
    for (int k = 0; k < DD_BITS; k++) begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
        if (bcd_step[i*4 +: 4] >= 4'd5) begin
          bcd_step[i*4 +: 4] = bcd_step[i*4 +: 4] + 4'd3;
        end
      end
      bcd_step = {bcd_step[BCD_W-2:0], s2_shift_r[SH_W-1-k]};
    end
  end

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    s2_cnt_nxt   = s2_cnt_r;
    s2_shift_nxt = s2_shift_r;
    s2_bcd_nxt   = s2_bcd_r;
    if (s1_adv) begin
      s2_valid_nxt = 1'b1;
      s2_cnt_nxt   = s1_is_dec ? CNT_W'(DD_STEPS) : '0;
      s2_shift_nxt = SH_W'(s1_mag_r);
      s2_bcd_nxt   = '0;
    end else if (s3_load) begin
      s2_valid_nxt = 1'b0;
    end else if (s2_valid_r && s2_cnt_r != '0) begin
      // advance four magnitude bits into the BCD register
      s2_cnt_nxt   = s2_cnt_r - 1'b1;
      s2_bcd_nxt   = bcd_step;
      s2_shift_nxt = s2_shift_r << DD_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_cnt_r   <= '0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
      s2_cnt_r   <= s2_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_shift_r <= s2_shift_nxt;
    s2_bcd_r   <= s2_bcd_nxt;
    if (s1_adv) begin
      s2_op_r  <= s1_op_r;
      s2_cmd_r <= s1_cmd_r;
      s2_ch_r  <= s1_ch_r;
      s2_len_r <= s1_len_r;
      s2_mag_r <= s1_mag_r;
      s2_neg_r <= s1_neg_r;
    end
  end

  // Gather digits of the selected base into one nibble-per-digit vector
  logic [DV_W-1:0] dvec;

  always_comb begin
    dvec = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      case (s2_op_r)
        clcd_pkg::OP_HEX: begin
          for (int b = 0; b < 4; b++) begin
            if (i * 4 + b < VALUE_BITS) begin
              dvec[i*4 + b] = s2_mag_r[i*4 + b];
            end
          end
        end
        clcd_pkg::OP_BIN: begin
          if (i < VALUE_BITS) begin
            dvec[i*4] = s2_mag_r[i];
          end
        end
        default: begin
          if (i < DEC_DIGITS) begin
            dvec[i*4 +: 4] = s2_bcd_r[i*4 +: 4];
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: byte emitter. One byte per cycle; loads the next converted
  // request in the cycle that sends the current request's last byte.
  // --------------------------------------------------------------------------
  logic             s3_valid_r, s3_valid_nxt;
  logic [1:0]       s3_phase_r, s3_phase_nxt;
  logic [LEN_W-1:0] s3_dig_r, s3_dig_nxt;
  logic [2:0]       s3_op_r;
  logic [7:0]       s3_cmd_r;
  logic [7:0]       s3_ch_r;
  logic             s3_neg_r;
  logic [DV_W-1:0]  s3_dvec_r;

  logic [7:0]       em_byte;
  logic             em_data;
  logic             em_last;
  logic [1:0]       em_phase_next;
  logic [IDX_W-1:0] dig_idx;
  logic [LEN_W-1:0] dig_idx_full;
  logic [3:0]       dig_val;

  assign dig_idx_full = s3_dig_r - 1'b1;
  assign dig_idx      = dig_idx_full[IDX_W-1:0];
  assign dig_val      = s3_dvec_r[{dig_idx, 2'b00} +: 4];

  always_comb begin
    em_byte       = s3_cmd_r;
    em_data       = 1'b0;
    em_last       = 1'b1;
    em_phase_next = PH_CMD;
    case (s3_phase_r)
      PH_CMD: begin
        em_byte = s3_cmd_r;
        em_data = 1'b0;
        if (s3_op_r == clcd_pkg::OP_CHAR) begin
          em_last       = 1'b0;
          em_phase_next = PH_CHAR;
        end else if (s3_op_r == clcd_pkg::OP_SDEC) begin
          em_last       = 1'b0;
          em_phase_next = PH_SIGN;
        end else if (s3_op_r inside {clcd_pkg::OP_UDEC, clcd_pkg::OP_HEX,
                                     clcd_pkg::OP_BIN}) begin
          em_last       = (s3_dig_r == '0);
          em_phase_next = PH_DIG;
        end else begin
          // unused operation code: cursor command only
          em_last = 1'b1;
        end
      end
      PH_CHAR: begin
        em_byte = s3_ch_r;
        em_data = 1'b1;
        em_last = 1'b1;
      end
      PH_SIGN: begin
        em_byte       = s3_neg_r ? clcd_pkg::ASCII_MINUS : clcd_pkg::ASCII_PLUS;
        em_data       = 1'b1;
        em_last       = (s3_dig_r == '0);
        em_phase_next = PH_DIG;
      end
      PH_DIG: begin
        if (dig_val < 4'd10) begin
          em_byte = clcd_pkg::ASCII_ZERO + {4'b0, dig_val};
        end else begin
          em_byte = clcd_pkg::ASCII_UPA + {4'b0, dig_val - 4'd10};
        end
        em_data       = 1'b1;
        em_last       = (s3_dig_r == LEN_W'(1));
        em_phase_next = PH_DIG;
      end
      default: begin
        em_last = 1'b1;
      end
    endcase
  end

  assign s3_load = s2_done & (~s3_valid_r | em_last);

  always_comb begin
    s3_valid_nxt = s3_valid_r;
    s3_phase_nxt = s3_phase_r;
    s3_dig_nxt   = s3_dig_r;
    if (s3_load) begin
      s3_valid_nxt = 1'b1;
      s3_phase_nxt = PH_CMD;
      s3_dig_nxt   = s2_len_r;
    end else if (s3_valid_r) begin
      if (em_last) begin
        s3_valid_nxt = 1'b0;
      end else begin
        s3_phase_nxt = em_phase_next;
        if (s3_phase_r == PH_DIG) begin
          s3_dig_nxt = s3_dig_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s3_phase_r <= PH_CMD;
      s3_dig_r   <= '0;
    end else begin
      s3_valid_r <= s3_valid_nxt;
      s3_phase_r <= s3_phase_nxt;
      s3_dig_r   <= s3_dig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_op_r   <= s2_op_r;
      s3_cmd_r  <= s2_cmd_r;
      s3_ch_r   <= s2_ch_r;
      s3_neg_r  <= s2_neg_r;
      s3_dvec_r <= dvec;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: hold each byte for exactly one cycle with its strobe.
  // --------------------------------------------------------------------------
  logic       out_strobe_r;
  logic [7:0] out_byte_r;
  logic       out_data_r;
  logic       out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= em_byte;
    out_data_r <= em_data;
    out_last_r <= em_last;
  end

  assign out_strobe   = out_strobe_r;
  assign out_bus_byte = out_byte_r;
  assign out_is_data  = out_data_r;
  assign out_last     = out_last_r;

endmodule
